// ===== design/fisr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisr_pkg
// Shared types and float helper functions for the reciprocal square root
// pipeline: single-precision multiply and add, each split into two halves.
// ----------------------------------------------------------------------------
package fisr_pkg;

  localparam logic [31:0] MagicReset = 32'h5F37_5A86;
  localparam logic [31:0] CanonNan   = 32'h7FC0_0000;
  localparam logic [31:0] OneHalf    = 32'h3F00_0000;
  localparam logic [31:0] ThreeHalf  = 32'h3FC0_0000;
  localparam logic [33:0] InfWord    = 34'h0_7F80_0000;

  typedef struct packed {
    logic        spec;
    logic [31:0] spec_bits;
    logic        sign;
    logic [8:0]  esum;
    logic [5:0]  pab;
    logic [47:0] prod;
  } fmul_mid_t;

  typedef struct packed {
    logic        spec;
    logic [31:0] spec_bits;
    logic        sign;
    logic        zsign;
    logic [7:0]  ebig;
    logic [27:0] sum;
  } fadd_mid_t;

  function automatic logic [4:0] lead24(input logic [23:0] m);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) p = 5'(i);
    end
    return p;
  endfunction

  function automatic logic [4:0] lead28(input logic [27:0] m);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 28; i++) begin
      if (m[i]) p = 5'(i);
    end
    return p;
  endfunction

  function automatic fmul_mid_t fmul_front(input logic [31:0] a, input logic [31:0] b);
    fmul_mid_t  r;
    logic       na, nb, ia, ib, za, zb, sg;
    logic [7:0] ea, eb;
    logic [23:0] ma, mb;
    sg = a[31] ^ b[31];
    na = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nb = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    ia = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    ib = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    za = (a[30:0] == 31'd0);
    zb = (b[30:0] == 31'd0);
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {(a[30:23] != 8'd0), a[22:0]};
    mb = {(b[30:23] != 8'd0), b[22:0]};
    r.sign = sg;
    r.esum = {1'b0, ea} + {1'b0, eb};
    r.pab  = {1'b0, lead24(ma)} + {1'b0, lead24(mb)};
    r.prod = {24'd0, ma} * {24'd0, mb};
    r.spec = 1'b1;
    if (na || nb || (ia && zb) || (za && ib)) begin
      r.spec_bits = CanonNan;
    end else if (ia || ib) begin
      r.spec_bits = {sg, 8'hFF, 23'd0};
    end else if (za || zb) begin
      r.spec_bits = {sg, 31'd0};
    end else begin
      r.spec      = 1'b0;
      r.spec_bits = 32'd0;
    end
    return r;
  endfunction

  function automatic logic [31:0] fmul_back(input fmul_mid_t m);
    logic [5:0]         p;
    logic signed [10:0] sn, ss, s, fs;
    logic [47:0]        q, mask;
    logic               g, st, inc;
    logic [33:0]        word;
    logic [31:0]        res;
    p  = m.pab + {5'd0, m.prod[m.pab + 6'd1]};
    sn = $signed({5'd0, p}) - 11'sd23;
    ss = 11'sd151 - $signed({2'd0, m.esum});
    s  = (sn > ss) ? sn : ss;
    fs = s + $signed({2'd0, m.esum}) - 11'sd151;
    if (s >= 11'sd49) begin
      q    = 48'd0;
      g    = 1'b0;
      st   = |m.prod;
      mask = 48'd0;
    end else begin
      q = m.prod >> s[5:0];
      if (s == 11'sd0) begin
        g    = 1'b0;
        mask = 48'd0;
      end else begin
        g    = m.prod[s[5:0] - 6'd1];
        mask = (48'd1 << (s[5:0] - 6'd1)) - 48'd1;
      end
      st = |(m.prod & mask);
    end
    inc  = g & (st | q[0]);
    word = {1'b0, fs[9:0], 23'd0} + {10'd0, q[23:0]} + {33'd0, inc};
    if (word >= InfWord) begin
      res = {m.sign, 8'hFF, 23'd0};
    end else begin
      res = {m.sign, word[30:0]};
    end
    return m.spec ? m.spec_bits : res;
  endfunction

  function automatic fadd_mid_t fadd_front(input logic [31:0] a, input logic [31:0] b);
    fadd_mid_t   r;
    logic        na, nb, ia, ib, big_a, st;
    logic [7:0]  ea, eb, e_big, e_sml, d;
    logic [23:0] ma, mb, m_big, m_sml;
    logic [26:0] s3, al, mask;
    logic [27:0] big3, sml;
    na = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nb = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    ia = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    ib = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {(a[30:23] != 8'd0), a[22:0]};
    mb = {(b[30:23] != 8'd0), b[22:0]};
    big_a = (a[30:0] >= b[30:0]);
    e_big = big_a ? ea : eb;
    e_sml = big_a ? eb : ea;
    m_big = big_a ? ma : mb;
    m_sml = big_a ? mb : ma;
    d  = e_big - e_sml;
    s3 = {m_sml, 3'd0};
    if (d >= 8'd27) begin
      al = 27'd0;
      st = |m_sml;
    end else begin
      al   = s3 >> d[4:0];
      mask = (27'd1 << d[4:0]) - 27'd1;
      st   = |(s3 & mask);
    end
    sml  = {1'b0, al | {26'd0, st}};
    big3 = {1'b0, m_big, 3'd0};
    r.sum   = (a[31] ^ b[31]) ? (big3 - sml) : (big3 + sml);
    r.sign  = big_a ? a[31] : b[31];
    r.zsign = a[31] & b[31];
    r.ebig  = e_big;
    r.spec  = 1'b1;
    if (na || nb || (ia && ib && (a[31] != b[31]))) begin
      r.spec_bits = CanonNan;
    end else if (ia) begin
      r.spec_bits = {a[31], 8'hFF, 23'd0};
    end else if (ib) begin
      r.spec_bits = {b[31], 8'hFF, 23'd0};
    end else begin
      r.spec      = 1'b0;
      r.spec_bits = 32'd0;
    end
    return r;
  endfunction

  function automatic logic [31:0] fadd_back(input fadd_mid_t m);
    logic [4:0]        p;
    logic signed [9:0] sn, ss, s, fs, ns;
    logic [27:0]       q, mask;
    logic              g, st, inc;
    logic [33:0]       word;
    logic [31:0]       res;
    p  = lead28(m.sum);
    sn = $signed({5'd0, p}) - 10'sd23;
    ss = 10'sd4 - $signed({2'd0, m.ebig});
    s  = (sn > ss) ? sn : ss;
    fs = s + $signed({2'd0, m.ebig}) - 10'sd4;
    ns = -s;
    if (s < 10'sd0) begin
      q    = m.sum << ns[4:0];
      g    = 1'b0;
      mask = 28'd0;
    end else if (s == 10'sd0) begin
      q    = m.sum;
      g    = 1'b0;
      mask = 28'd0;
    end else begin
      q    = m.sum >> s[4:0];
      g    = m.sum[s[4:0] - 5'd1];
      mask = (28'd1 << (s[4:0] - 5'd1)) - 28'd1;
    end
    st   = |(m.sum & mask);
    inc  = g & (st | q[0]);
    word = {2'd0, fs[8:0], 23'd0} + {10'd0, q[23:0]} + {33'd0, inc};
    if (word >= InfWord) begin
      res = {m.sign, 8'hFF, 23'd0};
    end else begin
      res = {m.sign, word[30:0]};
    end
    if (m.spec) begin
      res = m.spec_bits;
    end else if (m.sum == 28'd0) begin
      res = {m.zsign, 31'd0};
    end
    return res;
  endfunction

endpackage

// ===== design/fisr_fmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisr_fmul
// Two-stage single-precision multiplier. The first stage forms the mantissa
// product, the second normalizes and rounds to nearest even. A side word
// travels along with each request.
// ----------------------------------------------------------------------------
module fisr_fmul
  import fisr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] in_aux,
  output logic        out_valid,
  output logic [31:0] product,
  output logic [31:0] out_aux
);

  fmul_mid_t   mid;
  logic [31:0] mid_aux;
  logic        mid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid     <= fmul_front(a, b);
      mid_aux <= in_aux;
      product <= fmul_back(mid);
      out_aux <= mid_aux;
    end
  end

endmodule

// ===== design/fisr_fadd.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisr_fadd
// Two-stage single-precision adder. The first stage aligns and adds, the
// second normalizes and rounds to nearest even. A side word travels along.
// ----------------------------------------------------------------------------
module fisr_fadd
  import fisr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] in_aux,
  output logic        out_valid,
  output logic [31:0] sum,
  output logic [31:0] out_aux
);

  fadd_mid_t   mid;
  logic [31:0] mid_aux;
  logic        mid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid     <= fadd_front(a, b);
      mid_aux <= in_aux;
      sum     <= fadd_back(mid);
      out_aux <= mid_aux;
    end
  end

endmodule

// ===== design/fast_inverse_sqrt_single_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fast_inverse_sqrt_single_core
// Approximate reciprocal square root of an IEEE single: integer first guess
// followed by one Newton step in rounded float arithmetic.
// ----------------------------------------------------------------------------
// The block accepts one request per cycle while the output is not stalled;
// each result passes through five float units of two register stages each
// (four multipliers and one adder in a chain). When the output is stalled the
// whole pipeline holds, so number_stall follows result_stall while a result
// waits. NaN results always come out as 0x7FC00000. Write magic_constant only
// while no request is in flight.
module fast_inverse_sqrt_single_core
  import fisr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        magic_constant_we,
  input  logic [31:0] magic_constant_wdata,
  input  logic        number_valid,
  output logic        number_stall,
  input  logic [31:0] number_bits,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] result_bits
);

  logic [31:0] magic_constant;
  logic        en;
  logic [31:0] guess;
  logic        half_valid, t_valid, u_valid, v_valid;
  logic [31:0] half_val, half_y, t_val, t_y, u_val, u_y, v_val, v_y, r_val, r_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_constant <= MagicReset;
    end else if (magic_constant_we) begin
      magic_constant <= magic_constant_wdata;
    end
  end

  assign en           = !(result_valid && result_stall);
  assign number_stall = !en;
  assign guess        = magic_constant - {number_bits[31], number_bits[31:1]};

  fisr_fmul u_half (
    .clk(clk), .rst(rst), .en(en), .in_valid(number_valid),
    .a(number_bits), .b(OneHalf), .in_aux(guess),
    .out_valid(half_valid), .product(half_val), .out_aux(half_y)
  );

  fisr_fmul u_t (
    .clk(clk), .rst(rst), .en(en), .in_valid(half_valid),
    .a(half_val), .b(half_y), .in_aux(half_y),
    .out_valid(t_valid), .product(t_val), .out_aux(t_y)
  );

  fisr_fmul u_u (
    .clk(clk), .rst(rst), .en(en), .in_valid(t_valid),
    .a(t_val), .b(t_y), .in_aux(t_y),
    .out_valid(u_valid), .product(u_val), .out_aux(u_y)
  );

  fisr_fadd u_v (
    .clk(clk), .rst(rst), .en(en), .in_valid(u_valid),
    .a(ThreeHalf), .b({~u_val[31], u_val[30:0]}), .in_aux(u_y),
    .out_valid(v_valid), .sum(v_val), .out_aux(v_y)
  );

  fisr_fmul u_r (
    .clk(clk), .rst(rst), .en(en), .in_valid(v_valid),
    .a(v_y), .b(v_val), .in_aux(v_y),
    .out_valid(result_valid), .product(r_val), .out_aux(r_y)
  );

  assign result_bits = ((r_val[30:23] == 8'hFF) && (r_val[22:0] != 23'd0) &&
                        (r_y == r_y)) ? CanonNan : r_val;

endmodule

// ===== tb/tb_fast_inverse_sqrt_single_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fast_inverse_sqrt_single_core
// Self-checking bench for the reciprocal square root core. An independent
// bit-exact model of the integer guess and the rounded Newton step predicts
// every result. Requests and results move under random gaps and stalls, and
// the run passes through several values of magic_constant, the extremes
// among them.
// ----------------------------------------------------------------------------
module tb_fast_inverse_sqrt_single_core;
  import fisr_pkg::*;

  class rsqrt_scoreboard;
    logic [31:0] magic;
    logic [31:0] pending[$];
    int          errors;

    function new();
      magic  = MagicReset;
      errors = 0;
    endfunction

    task report(input string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    function automatic logic [31:0] round_pack(input logic sg, input logic [65:0] m,
                                               input int e);
      int          p, be, sh;
      logic [65:0] q;
      logic        g, st, inc;
      logic [33:0] word;
      if (m == 66'd0) return {sg, 31'd0};
      p = 0;
      for (int i = 0; i < 66; i++) if (m[i]) p = i;
      be = p + e + 127;
      sh = p - 23;
      if (be < 1) begin
        sh = sh + 1 - be;
        be = 1;
      end
      if (sh <= 0) begin
        q  = m << (-sh);
        g  = 1'b0;
        st = 1'b0;
      end else if (sh > 66) begin
        q  = 66'd0;
        g  = 1'b0;
        st = 1'b1;
      end else begin
        q  = m >> sh;
        g  = m[sh-1];
        st = (sh > 1) ? |(m & ((66'd1 << (sh - 1)) - 66'd1)) : 1'b0;
      end
      inc  = g & (st | q[0]);
      word = (34'(be - 1) << 23) + {10'd0, q[23:0]} + {33'd0, inc};
      if (word >= 34'h0_7F80_0000) return {sg, 8'hFF, 23'd0};
      return {sg, word[30:0]};
    endfunction

    function automatic logic is_nan(input logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    endfunction

    function automatic logic [23:0] mant(input logic [31:0] a);
      return {(a[30:23] != 8'd0), a[22:0]};
    endfunction

    function automatic int expo(input logic [31:0] a);
      return (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic        sg;
      logic [47:0] pr;
      sg = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) return CanonNan;
      if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0))
        return CanonNan;
      if (is_inf(a) || is_inf(b)) return {sg, 8'hFF, 23'd0};
      pr = {24'd0, mant(a)} * {24'd0, mant(b)};
      return round_pack(sg, {18'd0, pr}, expo(a) + expo(b) - 300);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] bg, sm;
      int          d, sh;
      logic [65:0] mb, ms, m;
      logic        sg;
      if (is_nan(a) || is_nan(b)) return CanonNan;
      if (is_inf(a) && is_inf(b) && a[31] != b[31]) return CanonNan;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      if (expo(a) >= expo(b)) begin
        bg = a;
        sm = b;
      end else begin
        bg = b;
        sm = a;
      end
      d  = expo(bg) - expo(sm);
      sh = (d > 40) ? 40 : d;
      mb = {42'd0, mant(bg)} << sh;
      ms = (d > 40) ? {65'd0, (mant(sm) != 24'd0)} : {42'd0, mant(sm)};
      if (bg[31] == sm[31]) begin
        m  = mb + ms;
        sg = bg[31];
      end else if (mb >= ms) begin
        m  = mb - ms;
        sg = bg[31];
      end else begin
        m  = ms - mb;
        sg = sm[31];
      end
      if (m == 66'd0) sg = a[31] & b[31];
      return round_pack(sg, m, expo(bg) - 150 - sh);
    endfunction

    function automatic logic [31:0] rsqrt(input logic [31:0] x);
      logic [31:0] y, half, t, u, v, r;
      y    = magic - {x[31], x[31:1]};
      half = fp_mul(x, OneHalf);
      t    = fp_mul(half, y);
      u    = fp_mul(t, y);
      v    = fp_add(ThreeHalf, {~u[31], u[30:0]});
      r    = fp_mul(y, v);
      return is_nan(r) ? CanonNan : r;
    endfunction

    function void note_request(input logic [31:0] x);
      pending.push_back(rsqrt(x));
    endfunction

    task check_result(input logic [31:0] got);
      logic [31:0] want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result_bits %h", got));
      end else begin
        want = pending.pop_front();
        if (got !== want) report($sformatf("result_bits %h, expected %h", got, want));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        magic_constant_we = 1'b0;
  logic [31:0] magic_constant_wdata = 32'd0;
  logic        number_valid = 1'b0;
  logic        number_stall;
  logic [31:0] number_bits = 32'd0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [31:0] result_bits;

  rsqrt_scoreboard sb = new();
  int  cycles = 0;
  bit  no_gaps = 1'b0;
  localparam int CycleLimit = 400000;

  fast_inverse_sqrt_single_core dut (
    .clk                  (clk),
    .rst                  (rst),
    .magic_constant_we    (magic_constant_we),
    .magic_constant_wdata (magic_constant_wdata),
    .number_valid         (number_valid),
    .number_stall         (number_stall),
    .number_bits          (number_bits),
    .result_valid         (result_valid),
    .result_stall         (result_stall),
    .result_bits          (result_bits)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result_bits);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  always @(negedge clk) begin
    int n;
    if (!rst) begin
      n = pick_gap();
      result_stall <= (n != 0);
      repeat (n) @(negedge clk);
      result_stall <= 1'b0;
    end
  end

  task send_request(input logic [31:0] x);
    int n;
    n = pick_gap();
    if (n != 0) begin
      number_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    number_valid <= 1'b1;
    number_bits  <= x;
    do @(posedge clk); while (number_stall);
    sb.note_request(x);
    @(negedge clk);
  endtask

  task drain();
    number_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (15) @(posedge clk);
    @(negedge clk);
  endtask

  task write_magic(input logic [31:0] value);
    drain();
    magic_constant_we    <= 1'b1;
    magic_constant_wdata <= value;
    @(negedge clk);
    magic_constant_we <= 1'b0;
    sb.magic = value;
  endtask

  function automatic logic [31:0] random_number();
    logic [31:0] specials[8];
    specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'h3F80_0000};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return {1'b0, 8'($urandom_range(1, 254)), 23'($urandom)};
      5, 6:          return $urandom;
      7:             return {1'($urandom), 8'd0, 23'($urandom)};
      8:             return specials[$urandom_range(0, 7)];
      default:       return {1'($urandom), ($urandom_range(0, 1) ? 8'd1 : 8'($urandom_range(252, 254))),
                             23'($urandom)};
    endcase
  endfunction

  initial begin
    logic [31:0] directed[$];
    logic [31:0] settings[5];
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'hFFC1_2345, 32'h7F80_0001, 32'hFFFF_FFFF,
                 32'h0000_0001, 32'h007F_FFFF, 32'h0080_0000, 32'h7F7F_FFFF,
                 32'h3F80_0000, 32'h4080_0000, 32'hBF80_0000, 32'h3E80_0000,
                 32'h5F37_59DF, 32'h4B00_0000, 32'h8000_0001, 32'h2000_0000};
    settings = '{MagicReset, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, MagicReset};
    settings[3] = $urandom;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_request(directed[i]);
    for (int ph = 0; ph < 5; ph++) begin
      write_magic(settings[ph]);
      for (int k = 0; k < 127; k++) begin
        no_gaps = (k >= 40 && k < 70);
        if (ph == 2 && k == 60) drain();
        send_request(random_number());
      end
      no_gaps = 1'b0;
    end
    number_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/fisr_pkg.sv
design/fisr_fmul.sv
design/fisr_fadd.sv
design/fast_inverse_sqrt_single_core.sv
tb/tb_fast_inverse_sqrt_single_core.sv
